>>> rtl/core/assert_macros.svh
// Assertion macros for the interpolator RTL.
// Expects signals clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define KNN_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant violated");

`define KNN_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication violated");

`define KNN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`else

`define KNN_ASSERT_ALWAYS(lbl, expr)
`define KNN_ASSERT_IMPL(lbl, ante, cons)
`define KNN_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/knn_idw_pkg.sv
// Shared types and constants for the k-nearest inverse-distance interpolator.
// No dependencies.
package knn_idw_pkg;

	localparam int DEF_MAX_POINTS     = 1024;
	localparam int DEF_MAX_NEIGHBOURS = 16;

	localparam int COORD_W = 24;
	localparam int VALUE_W = 32;
	localparam int NC_W    = 5;
	localparam int PWR_W   = 12;
	localparam int CFG_W   = 12;
	localparam int D2_W    = 50;
	localparam int T_W     = 36;
	localparam int MUL_W   = 33;
	localparam int ROOT_W  = 31;
	localparam int WGT_W   = 25;
	localparam int NUM_W   = 64;
	localparam int DEN_W   = 32;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_QUERY = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [0:0] REG_NEIGHBOUR_COUNT = 1'b0;
	localparam logic [0:0] REG_POWER_Q8        = 1'b1;

	localparam logic [NC_W-1:0]  NC_RESET  = 5'd8;
	localparam logic [PWR_W-1:0] PWR_RESET = 12'd512;

	// integer square root seeds: 2^-1 in Q.30, shifted up by 30
	localparam logic [60:0] ISQRT_V0   = 61'd1 << 59;
	localparam logic [60:0] ISQRT_BIT0 = 61'd1 << 60;

	localparam logic [11:0] SHIFT_BIAS  = 12'd6;
	localparam logic [11:0] SHIFT_LIMIT = 12'd40;
	localparam logic [5:0]  LOG_TOP     = 6'd49;
	localparam logic [6:0]  LOG_BIAS    = 7'd24;

	typedef struct packed {
		logic [1:0]                 mode;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic signed [VALUE_W-1:0] sample_value;
	} in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] interp_value;
		logic                       empty_flag;
		logic                       store_full;
	} out_t;

endpackage

>>> rtl/core/knn_idw_div.sv
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on knn_idw_pkg.
module knn_idw_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [knn_idw_pkg::NUM_W-1:0]   dividend,
	input  logic [knn_idw_pkg::DEN_W-1:0]          divisor,
	output logic                                   done,
	output logic signed [knn_idw_pkg::NUM_W-1:0]   quotient
);

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

	dstate_t                          state_q;
	logic [5:0]                       cnt_q;
	logic                             done_q;
	logic [knn_idw_pkg::NUM_W-1:0]    mag_q;
	logic [knn_idw_pkg::DEN_W-1:0]    rem_q;
	logic [knn_idw_pkg::DEN_W-1:0]    den_q;
	logic                             neg_q;
	logic signed [knn_idw_pkg::NUM_W-1:0] quo_q;

	logic [knn_idw_pkg::DEN_W:0]      rem_sh;
	logic                             fits;

	assign rem_sh = {rem_q, mag_q[knn_idw_pkg::NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63)
						state_q <= D_FIN;
				end
				D_FIN: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					mag_q <= dividend[knn_idw_pkg::NUM_W-1] ? -dividend : dividend;
					neg_q <= dividend[knn_idw_pkg::NUM_W-1];
					den_q <= (divisor == '0) ? knn_idw_pkg::DEN_W'(1) : divisor;
					rem_q <= '0;
				end
			end
			D_RUN: begin
				rem_q <= fits ? knn_idw_pkg::DEN_W'(rem_sh - {1'b0, den_q})
				              : rem_sh[knn_idw_pkg::DEN_W-1:0];
				mag_q <= {mag_q[knn_idw_pkg::NUM_W-2:0], fits};
			end
			D_FIN: quo_q <= neg_q ? -signed'(mag_q) : signed'(mag_q);
			default: ;
		endcase
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/core/knn_inverse_distance_interp.sv
// k-nearest inverse-distance interpolator: point store, brute-force scan, weighting.
// Load and clear give no beat; refused load and empty-store query beat the next cycle.
// Query: brute-force scan over the N stored points, then on an exact hit the stored value;
// else log and weight steps per neighbour, then the divider. One command at a time.
// Reset clears count, loads defaults; busy stays high while the root table is built.
// Results are one-cycle beats on done, no stall. Needs knn_idw_pkg, knn_idw_div, macros.
`include "assert_macros.svh"

module knn_inverse_distance_interp #(
	parameter int MAX_POINTS     = knn_idw_pkg::DEF_MAX_POINTS,
	parameter int MAX_NEIGHBOURS = knn_idw_pkg::DEF_MAX_NEIGHBOURS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  knn_idw_pkg::in_t                  item,
	output logic                              done,
	output knn_idw_pkg::out_t                 result,
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_addr,
	input  logic [knn_idw_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int KW = $clog2(MAX_NEIGHBOURS + 1);
	localparam int JW = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

	typedef enum logic [4:0] {
		S_ROOT, S_IDLE,
		S_SC_RD, S_SC_DIF, S_SC_MX, S_SC_MY, S_SC_MZ, S_SC_INS, S_SC_END,
		S_HIT_RD, S_HIT_OUT,
		S_LG_LD, S_LG_NORM, S_LG_SQ, S_LG_T,
		S_WT_RD, S_WT_EXP, S_WT_SH, S_WT_ACC,
		S_DIV_GO, S_DIV_WAIT
	} state_t;

	typedef struct packed {
		logic signed [knn_idw_pkg::COORD_W-1:0] x;
		logic signed [knn_idw_pkg::COORD_W-1:0] y;
		logic signed [knn_idw_pkg::COORD_W-1:0] z;
		logic signed [knn_idw_pkg::VALUE_W-1:0] v;
	} entry_t;

	// control
	state_t                             state_q;
	logic [knn_idw_pkg::NC_W-1:0]       nc_q;
	logic [knn_idw_pkg::PWR_W-1:0]      pwr_q;
	logic [CW-1:0]                      count_q;
	logic [CW-1:0]                      i_q;
	logic [JW-1:0]                      j_q;
	logic [KW-1:0]                      k_q;
	logic [KW-1:0]                      filled_q;
	logic [3:0]                         s_q;
	logic [3:0]                         ridx_q;
	logic [60:0]                        iv_q;
	logic [60:0]                        ires_q;
	logic [60:0]                        ibit_q;
	logic                               done_q;
	knn_idw_pkg::out_t                  res_q;

	// datapath
	entry_t                             mem [MAX_POINTS];
	entry_t                             rd_q;
	logic signed [knn_idw_pkg::COORD_W-1:0] qx_q, qy_q, qz_q;
	logic [knn_idw_pkg::COORD_W-1:0]    adx_q, ady_q, adz_q;
	logic [knn_idw_pkg::D2_W-1:0]       d2_q;
	logic [knn_idw_pkg::D2_W-1:0]       best_d_q [MAX_NEIGHBOURS];
	logic [AW-1:0]                      best_s_q [MAX_NEIGHBOURS];
	logic [knn_idw_pkg::D2_W-1:0]       nrm_q;
	logic [5:0]                         m_q;
	logic [knn_idw_pkg::ROOT_W-1:0]     x_q;
	logic [15:0]                        frac_q;
	logic signed [knn_idw_pkg::T_W-1:0] t_q [MAX_NEIGHBOURS];
	logic signed [knn_idw_pkg::T_W-1:0] tmin_q;
	logic [15:0]                        f_q;
	logic [11:0]                        sh_q;
	logic [knn_idw_pkg::ROOT_W-1:0]     w_q;
	logic [knn_idw_pkg::WGT_W-1:0]      weight_q;
	logic signed [knn_idw_pkg::NUM_W-1:0] num_q;
	logic [knn_idw_pkg::DEN_W-1:0]      den_q;
	logic [knn_idw_pkg::ROOT_W-1:0]     root_q [16];

	// combinational
	logic                               acc;
	logic                               wr_en;
	logic                               rd_en;
	logic [AW-1:0]                      rd_addr;
	logic [KW-1:0]                      k_nx;
	logic [5:0]                         kc;
	logic signed [knn_idw_pkg::MUL_W-1:0] mul_a, mul_b;
	logic signed [2*knn_idw_pkg::MUL_W-1:0] mul_p;
	logic [60:0]                        isum, ires_nx, iv_nx;
	logic [MAX_NEIGHBOURS-1:0]          le, take_d, take_prev;
	logic                               ins;
	logic                               last_j;
	logic signed [knn_idw_pkg::COORD_W:0] dx, dy, dz;
	logic [6:0]                         m_rel;
	logic signed [22:0]                 l_val;
	logic [31:0]                        sq;
	logic signed [knn_idw_pkg::T_W-1:0] t_new;
	logic signed [knn_idw_pkg::T_W-1:0] dd;
	logic                               div_start;
	logic                               div_done;
	logic signed [knn_idw_pkg::NUM_W-1:0] div_q;

	assign busy   = (state_q != S_IDLE);
	assign acc    = start && !busy;
	assign wr_en  = acc && (item.mode == knn_idw_pkg::MODE_LOAD)
	                && (count_q != CW'(MAX_POINTS));
	assign last_j = (32'(j_q) + 32'd1) == 32'(k_q);
	assign div_start = (state_q == S_DIV_GO);

	always_comb begin
		kc = (nc_q == 5'd0) ? 6'd1 : {1'b0, nc_q};
		if (32'(kc) > 32'(MAX_NEIGHBOURS))
			k_nx = KW'(MAX_NEIGHBOURS);
		else
			k_nx = KW'(kc);
		if (32'(k_nx) > 32'(count_q))
			k_nx = KW'(count_q);
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_SC_RD: begin
				rd_en   = 1'b1;
				rd_addr = i_q[AW-1:0];
			end
			S_HIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = best_s_q[0];
			end
			S_WT_RD: begin
				rd_en   = 1'b1;
				rd_addr = best_s_q[j_q];
			end
			default: ;
		endcase
	end

	// integer square root step for the root table
	always_comb begin
		isum = ires_q + ibit_q;
		if (iv_q >= isum) begin
			iv_nx   = iv_q - isum;
			ires_nx = (ires_q >> 1) + ibit_q;
		end else begin
			iv_nx   = iv_q;
			ires_nx = ires_q >> 1;
		end
	end

	assign dx = 25'(qx_q) - 25'(rd_q.x);
	assign dy = 25'(qy_q) - 25'(rd_q.y);
	assign dz = 25'(qz_q) - 25'(rd_q.z);

	assign m_rel = {1'b0, m_q} - knn_idw_pkg::LOG_BIAS;
	assign l_val = signed'({m_rel, frac_q});

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SC_MX: begin
				mul_a = 33'(adx_q);
				mul_b = 33'(adx_q);
			end
			S_SC_MY: begin
				mul_a = 33'(ady_q);
				mul_b = 33'(ady_q);
			end
			S_SC_MZ: begin
				mul_a = 33'(adz_q);
				mul_b = 33'(adz_q);
			end
			S_LG_SQ: begin
				mul_a = 33'(x_q);
				mul_b = 33'(x_q);
			end
			S_LG_T: begin
				mul_a = 33'(pwr_q);
				mul_b = 33'(l_val);
			end
			S_WT_EXP: begin
				mul_a = 33'(w_q);
				mul_b = 33'(root_q[s_q]);
			end
			S_WT_ACC: begin
				mul_a = 33'(rd_q.v);
				mul_b = 33'(weight_q);
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign sq    = mul_p[61:30];
	assign t_new = signed'(mul_p[knn_idw_pkg::T_W-1:0]);
	assign dd    = t_q[j_q] - tmin_q;

	// sorted neighbour list: every slot decides its own move
	always_comb begin
		for (int j = 0; j < MAX_NEIGHBOURS; j++)
			le[j] = (j < int'(filled_q)) && (best_d_q[j] <= d2_q);
		ins = (filled_q < k_q) || !le[JW'(k_q - KW'(1))];
		for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
			take_d[j]    = ins && (j < int'(k_q)) && !le[j] && ((j == 0) || le[(j > 0) ? j - 1 : 0]);
			take_prev[j] = ins && (j > 0) && (j < int'(k_q)) && (j <= int'(filled_q))
			               && !le[(j > 0) ? j - 1 : 0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_ROOT;
			nc_q     <= knn_idw_pkg::NC_RESET;
			pwr_q    <= knn_idw_pkg::PWR_RESET;
			count_q  <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			filled_q <= '0;
			s_q      <= '0;
			ridx_q   <= '0;
			iv_q     <= knn_idw_pkg::ISQRT_V0;
			ires_q   <= '0;
			ibit_q   <= knn_idw_pkg::ISQRT_BIT0;
			done_q   <= 1'b0;
			res_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_addr)
					knn_idw_pkg::REG_NEIGHBOUR_COUNT: nc_q <= cfg_wdata[knn_idw_pkg::NC_W-1:0];
					knn_idw_pkg::REG_POWER_Q8:        pwr_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				S_ROOT: begin
					if (ibit_q == 61'd1) begin
						iv_q   <= 61'(ires_nx[knn_idw_pkg::ROOT_W-1:0]) << 30;
						ires_q <= '0;
						ibit_q <= knn_idw_pkg::ISQRT_BIT0;
						ridx_q <= ridx_q + 4'd1;
						if (ridx_q == 4'd15)
							state_q <= S_IDLE;
					end else begin
						iv_q   <= iv_nx;
						ires_q <= ires_nx;
						ibit_q <= ibit_q >> 2;
					end
				end
				S_IDLE: begin
					if (acc) begin
						case (item.mode)
							knn_idw_pkg::MODE_CLEAR: count_q <= '0;
							knn_idw_pkg::MODE_LOAD: begin
								if (count_q == CW'(MAX_POINTS)) begin
									done_q <= 1'b1;
									res_q  <= '{interp_value: '0, empty_flag: 1'b0,
									           store_full: 1'b1};
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							knn_idw_pkg::MODE_QUERY: begin
								if (count_q == '0) begin
									done_q <= 1'b1;
									res_q  <= '{interp_value: '0, empty_flag: 1'b1,
									           store_full: 1'b0};
								end else begin
									k_q      <= k_nx;
									filled_q <= '0;
									i_q      <= '0;
									state_q  <= S_SC_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_SC_RD:  state_q <= S_SC_DIF;
				S_SC_DIF: state_q <= S_SC_MX;
				S_SC_MX:  state_q <= S_SC_MY;
				S_SC_MY:  state_q <= S_SC_MZ;
				S_SC_MZ:  state_q <= S_SC_INS;
				S_SC_INS: begin
					if (filled_q < k_q)
						filled_q <= filled_q + KW'(1);
					i_q <= i_q + CW'(1);
					if (i_q + CW'(1) == count_q)
						state_q <= S_SC_END;
					else
						state_q <= S_SC_RD;
				end
				S_SC_END: begin
					j_q <= '0;
					if (best_d_q[0] == '0)
						state_q <= S_HIT_RD;
					else
						state_q <= S_LG_LD;
				end
				S_HIT_RD: state_q <= S_HIT_OUT;
				S_HIT_OUT: begin
					done_q  <= 1'b1;
					res_q   <= '{interp_value: rd_q.v, empty_flag: 1'b0, store_full: 1'b0};
					state_q <= S_IDLE;
				end
				S_LG_LD: state_q <= S_LG_NORM;
				S_LG_NORM: begin
					if (nrm_q[knn_idw_pkg::D2_W-1]) begin
						s_q     <= '0;
						state_q <= S_LG_SQ;
					end
				end
				S_LG_SQ: begin
					s_q <= s_q + 4'd1;
					if (s_q == 4'd15)
						state_q <= S_LG_T;
				end
				S_LG_T: begin
					if (last_j) begin
						j_q     <= '0;
						state_q <= S_WT_RD;
					end else begin
						j_q     <= j_q + JW'(1);
						state_q <= S_LG_LD;
					end
				end
				S_WT_RD: begin
					s_q     <= '0;
					state_q <= S_WT_EXP;
				end
				S_WT_EXP: begin
					s_q <= s_q + 4'd1;
					if (s_q == 4'd15)
						state_q <= S_WT_SH;
				end
				S_WT_SH: state_q <= S_WT_ACC;
				S_WT_ACC: begin
					if (last_j) begin
						state_q <= S_DIV_GO;
					end else begin
						j_q     <= j_q + JW'(1);
						state_q <= S_WT_RD;
					end
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						done_q  <= 1'b1;
						res_q   <= '{interp_value: div_q[knn_idw_pkg::VALUE_W-1:0],
						           empty_flag: 1'b0, store_full: 1'b0};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[count_q[AW-1:0]] <= '{x: item.coord_x, y: item.coord_y, z: item.coord_z,
			                          v: item.sample_value};
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_ROOT: begin
				if (ibit_q == 61'd1)
					root_q[ridx_q] <= ires_nx[knn_idw_pkg::ROOT_W-1:0];
			end
			S_IDLE: begin
				if (acc && item.mode == knn_idw_pkg::MODE_QUERY) begin
					qx_q <= item.coord_x;
					qy_q <= item.coord_y;
					qz_q <= item.coord_z;
				end
			end
			S_SC_DIF: begin
				adx_q <= dx[knn_idw_pkg::COORD_W] ? 24'(-dx) : 24'(dx);
				ady_q <= dy[knn_idw_pkg::COORD_W] ? 24'(-dy) : 24'(dy);
				adz_q <= dz[knn_idw_pkg::COORD_W] ? 24'(-dz) : 24'(dz);
			end
			S_SC_MX: d2_q <= mul_p[knn_idw_pkg::D2_W-1:0];
			S_SC_MY: d2_q <= d2_q + mul_p[knn_idw_pkg::D2_W-1:0];
			S_SC_MZ: d2_q <= d2_q + mul_p[knn_idw_pkg::D2_W-1:0];
			S_SC_INS: begin
				for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
					if (take_d[j]) begin
						best_d_q[j] <= d2_q;
						best_s_q[j] <= i_q[AW-1:0];
					end
				end
				for (int j = 1; j < MAX_NEIGHBOURS; j++) begin
					if (take_prev[j]) begin
						best_d_q[j] <= best_d_q[j-1];
						best_s_q[j] <= best_s_q[j-1];
					end
				end
			end
			S_SC_END: begin
				num_q <= '0;
				den_q <= '0;
			end
			S_LG_LD: begin
				nrm_q <= best_d_q[j_q];
				m_q   <= knn_idw_pkg::LOG_TOP;
			end
			S_LG_NORM: begin
				if (nrm_q[knn_idw_pkg::D2_W-1]) begin
					x_q    <= nrm_q[knn_idw_pkg::D2_W-1:19];
					frac_q <= '0;
				end else if (nrm_q[knn_idw_pkg::D2_W-1 -: 8] == 8'd0) begin
					nrm_q <= nrm_q << 8;
					m_q   <= m_q - 6'd8;
				end else begin
					nrm_q <= nrm_q << 1;
					m_q   <= m_q - 6'd1;
				end
			end
			S_LG_SQ: begin
				if (sq[31]) begin
					x_q                 <= sq[31:1];
					frac_q[4'd15 - s_q] <= 1'b1;
				end else begin
					x_q <= sq[30:0];
				end
			end
			S_LG_T: begin
				t_q[j_q] <= t_new;
				if (j_q == '0 || t_new < tmin_q)
					tmin_q <= t_new;
			end
			S_WT_RD: begin
				f_q  <= dd[24:9];
				sh_q <= 12'(dd[knn_idw_pkg::T_W-1:25]) + knn_idw_pkg::SHIFT_BIAS;
				w_q  <= 31'd1 << 30;
			end
			S_WT_EXP: begin
				if (f_q[4'd15 - s_q])
					w_q <= mul_p[60:30];
			end
			S_WT_SH: begin
				weight_q <= (sh_q < knn_idw_pkg::SHIFT_LIMIT)
				            ? knn_idw_pkg::WGT_W'(w_q >> sh_q[5:0]) : '0;
			end
			S_WT_ACC: begin
				num_q <= num_q + mul_p[knn_idw_pkg::NUM_W-1:0];
				den_q <= den_q + knn_idw_pkg::DEN_W'(weight_q);
			end
			default: ;
		endcase
	end

	knn_idw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign done   = done_q;
	assign result = res_q;

	`KNN_ASSERT_ALWAYS(a_fill_within_k, filled_q <= k_q)
	`KNN_ASSERT_ALWAYS(a_count_bound, 32'(count_q) <= 32'(MAX_POINTS))
	`KNN_ASSERT_IMPL(a_done_when_idle, done_q, state_q == S_IDLE)
	`KNN_ASSERT_NEXT(a_div_gives_beat, state_q == S_DIV_WAIT && div_done, done_q)

endmodule
